>>> rtl/core/ctt_pkg.sv
package ctt_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned MeasW = 14;
  localparam int unsigned SpW   = 11;
  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned SecW  = 6;
  localparam int unsigned ModeW = 3;
  localparam int unsigned HystW = 10;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = HystW;

  localparam logic [HystW-1:0] HystReset  = HystW'(10);
  localparam logic [HourW-1:0] LimitReset = HourW'(5);

  localparam logic [MinW-1:0] MinMax = MinW'(59);
  localparam logic [SecW-1:0] SecMax = SecW'(59);

  typedef enum logic [CmdW-1:0] {
    CMD_TICK   = 3'd0,
    CMD_MODE   = 3'd1,
    CMD_START  = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_UP     = 3'd4,
    CMD_DOWN   = 3'd5,
    CMD_CLEAR  = 3'd6,
    CMD_SAMPLE = 3'd7
  } cmd_e;

  localparam logic [ModeW-1:0] MODE_SEC     = 3'd0;
  localparam logic [ModeW-1:0] MODE_TEN_SEC = 3'd1;
  localparam logic [ModeW-1:0] MODE_MIN     = 3'd2;
  localparam logic [ModeW-1:0] MODE_TEN_MIN = 3'd3;
  localparam logic [ModeW-1:0] MODE_HOUR    = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_HYST       = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_HOUR_LIMIT = 1'b1;

endpackage

>>> rtl/core/cooking_timer_thermostat_unit.sv
// Countdown cooker controller with a hysteresis thermostat. Each accepted event
// (tick, mode, start, stop, up, down, clear, sample) yields exactly one result:
// the time, step mode, cooking and heater flags after the event, plus a buzzer
// flag for a tick that ended cooking at zero. One event is taken every clock
// cycle while in_stall_o is low; a result is offered once its event has passed
// the input register and then the state/result register. The time, mode and
// flag registers are updated by combinational logic, which sets that rate.
// The output channel is registered, so the input side keeps taking events while
// a result waits, until both the input and result registers are full.
// Configuration writes should only be made with no event in flight.
module cooking_timer_thermostat_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ctt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ctt_pkg::CmdW-1:0]      cmd_i,
  input  logic [ctt_pkg::MeasW-1:0]     measured_tenths_i,
  input  logic [ctt_pkg::SpW-1:0]       setpoint_tenths_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ctt_pkg::HourW-1:0]     hours_left_o,
  output logic [ctt_pkg::MinW-1:0]      minutes_left_o,
  output logic [ctt_pkg::SecW-1:0]      seconds_left_o,
  output logic [ctt_pkg::ModeW-1:0]     step_mode_o,
  output logic                          cooking_o,
  output logic                          heater_on_o,
  output logic                          buzzer_pulse_o
);
  import ctt_pkg::*;

  localparam int unsigned CmpW = MeasW + 1;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  min;
    logic [SecW-1:0]  sec;
  } time_t;

  function automatic time_t add_minutes(time_t t, logic [3:0] n);
    time_t      r;
    logic [6:0] sum;
    r   = t;
    sum = {1'b0, t.min} + {3'b000, n};
    if (sum <= {1'b0, MinMax}) begin
      r.min = sum[MinW-1:0];
    end else begin
      r.min  = MinW'(sum - 7'd60);
      r.hour = t.hour + HourW'(1);
    end
    return r;
  endfunction

  function automatic time_t add_seconds(time_t t, logic [3:0] n);
    time_t      r;
    logic [6:0] sum;
    r   = t;
    sum = {1'b0, t.sec} + {3'b000, n};
    if (sum <= {1'b0, SecMax}) begin
      r.sec = sum[SecW-1:0];
    end else begin
      r     = add_minutes(t, 4'd1);
      r.sec = SecW'(sum - 7'd60);
    end
    return r;
  endfunction

  function automatic time_t sub_seconds(time_t t, logic [3:0] n);
    time_t      r;
    logic [6:0] wrap;
    r    = t;
    wrap = {1'b0, t.sec} + 7'd60 - {3'b000, n};
    if (t.sec >= {2'b00, n}) begin
      r.sec = t.sec - {2'b00, n};
    end else if (t.min != '0) begin
      r.min = t.min - MinW'(1);
      r.sec = wrap[SecW-1:0];
    end else if (t.hour != '0) begin
      r.hour = t.hour - HourW'(1);
      r.min  = MinMax;
      r.sec  = wrap[SecW-1:0];
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic time_t sub_minutes(time_t t, logic [3:0] n);
    time_t      r;
    logic [6:0] wrap;
    r    = t;
    wrap = {1'b0, t.min} + 7'd60 - {3'b000, n};
    if (t.min >= {2'b00, n}) begin
      r.min = t.min - {2'b00, n};
    end else if (t.hour != '0) begin
      r.hour = t.hour - HourW'(1);
      r.min  = wrap[MinW-1:0];
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // configuration
  logic [HystW-1:0] hyst_q;
  logic [HourW-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q  <= HystReset;
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HYST:       hyst_q  <= cfg_wdata_i[HystW-1:0];
        REG_HOUR_LIMIT: limit_q <= cfg_wdata_i[HourW-1:0];
        default:        ;
      endcase
    end
  end

  // input register
  logic             s1_valid_q;
  logic [CmdW-1:0]  s1_cmd_q;
  logic [MeasW-1:0] s1_meas_q;
  logic [SpW-1:0]   s1_sp_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_xfer;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q  <= cmd_i;
      s1_meas_q <= measured_tenths_i;
      s1_sp_q   <= setpoint_tenths_i;
    end
  end

  // state, which doubles as the result register
  time_t            time_q, time_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic             run_q, run_d;
  logic             heat_q, heat_d;
  logic             buzz_q, buzz_d;

  time_t            up_time, down_time, tick_time;
  logic             time_nz;
  logic [CmpW-1:0]  lo_sum, hi_sum, meas_ext;

  assign time_nz   = (time_q != '0);
  assign tick_time = sub_seconds(time_q, 4'd1);
  assign meas_ext  = CmpW'(s1_meas_q);
  assign lo_sum    = meas_ext + CmpW'(hyst_q);
  assign hi_sum    = CmpW'(s1_sp_q) + CmpW'(hyst_q);

  always_comb begin
    up_time = time_q;
    if (time_q.hour < limit_q) begin
      unique case (mode_q)
        MODE_SEC:     up_time = add_seconds(time_q, 4'd1);
        MODE_TEN_SEC: up_time = add_seconds(time_q, 4'd10);
        MODE_MIN:     up_time = add_minutes(time_q, 4'd1);
        MODE_TEN_MIN: up_time = add_minutes(time_q, 4'd10);
        MODE_HOUR:    up_time.hour = time_q.hour + HourW'(1);
        default:      ;
      endcase
      // reaching the hour limit drops minutes and seconds
      if (up_time.hour == limit_q) begin
        up_time.min = '0;
        up_time.sec = '0;
      end
    end
  end

  always_comb begin
    down_time = time_q;
    unique case (mode_q)
      MODE_SEC:     down_time = sub_seconds(time_q, 4'd1);
      MODE_TEN_SEC: down_time = sub_seconds(time_q, 4'd10);
      MODE_MIN:     down_time = sub_minutes(time_q, 4'd1);
      MODE_TEN_MIN: down_time = sub_minutes(time_q, 4'd10);
      MODE_HOUR: begin
        if (time_q.hour != '0) begin
          down_time.hour = time_q.hour - HourW'(1);
        end else begin
          down_time = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    time_d = time_q;
    mode_d = mode_q;
    run_d  = run_q;
    heat_d = heat_q;
    buzz_d = 1'b0;
    unique case (cmd_e'(s1_cmd_q))
      CMD_TICK: begin
        if (run_q) begin
          if (time_nz) begin
            time_d = tick_time;
          end else begin
            run_d  = 1'b0;
            heat_d = 1'b0;
            buzz_d = 1'b1;
          end
        end
      end
      CMD_MODE:  mode_d = (mode_q >= MODE_HOUR) ? MODE_SEC : mode_q + ModeW'(1);
      CMD_START: run_d = run_q || time_nz;
      CMD_STOP: begin
        run_d  = 1'b0;
        heat_d = 1'b0;
      end
      CMD_UP:   time_d = up_time;
      CMD_DOWN: time_d = down_time;
      CMD_CLEAR: begin
        time_d = '0;
        run_d  = 1'b0;
        heat_d = 1'b0;
      end
      CMD_SAMPLE: begin
        // on below setpoint minus band, off above setpoint plus band
        if (run_q) begin
          priority if (lo_sum < CmpW'(s1_sp_q)) begin
            heat_d = 1'b1;
          end else if (meas_ext > hi_sum) begin
            heat_d = 1'b0;
          end else begin
            heat_d = heat_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      mode_q <= MODE_SEC;
      run_q  <= 1'b0;
      heat_q <= 1'b0;
      buzz_q <= 1'b0;
    end else if (advance) begin
      time_q <= time_d;
      mode_q <= mode_d;
      run_q  <= run_d;
      heat_q <= heat_d;
      buzz_q <= buzz_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hours_left_o   = time_q.hour;
  assign minutes_left_o = time_q.min;
  assign seconds_left_o = time_q.sec;
  assign step_mode_o    = mode_q;
  assign cooking_o      = run_q;
  assign heater_on_o    = heat_q;
  assign buzzer_pulse_o = buzz_q;

endmodule

>>> rtl/core/ctt_checker.sv
module ctt_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ctt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [ctt_pkg::CmdW-1:0]      cmd_i,
  input  logic [ctt_pkg::MeasW-1:0]     measured_tenths_i,
  input  logic [ctt_pkg::SpW-1:0]       setpoint_tenths_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [ctt_pkg::HourW-1:0]     hours_left_o,
  input  logic [ctt_pkg::MinW-1:0]      minutes_left_o,
  input  logic [ctt_pkg::SecW-1:0]      seconds_left_o,
  input  logic [ctt_pkg::ModeW-1:0]     step_mode_o,
  input  logic                          cooking_o,
  input  logic                          heater_on_o,
  input  logic                          buzzer_pulse_o
);
  import ctt_pkg::*;

  // a result held back by stall stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // the heater only runs while cooking
  a_heat_needs_cook: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heater_on_o |-> cooking_o)
    else $error("heater on while not cooking");

  // buzzer only on a finished countdown at zero
  a_buzz_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buzzer_pulse_o |->
      !cooking_o && !heater_on_o && hours_left_o == '0 &&
      minutes_left_o == '0 && seconds_left_o == '0)
    else $error("buzzer pulse with time left or still cooking");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_mode_o <= MODE_HOUR)
    else $error("step mode out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    minutes_left_o <= MinMax && seconds_left_o <= SecMax)
    else $error("minutes or seconds out of range");

endmodule

bind cooking_timer_thermostat_unit ctt_checker u_ctt_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import ctt_pkg::*;

  typedef struct packed {
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [ModeW-1:0] mode;
    logic             cooking;
    logic             heater;
    logic             buzzer;
  } cooker_view_t;

  typedef struct packed {
    cmd_e         cmd;
    int           meas;
    int           sp;
    bit           typed;
    cooker_view_t view;
  } directed_row_t;

  localparam cooker_view_t CLEARED = '0;
  localparam int DirectedRows = 29;

  logic                clk_i;
  logic                rst_ni            = 1'b0;
  logic                cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i       = '0;
  logic [CfgDataW-1:0] cfg_wdata_i       = '0;
  logic                in_valid_i        = 1'b0;
  logic                in_stall_o;
  logic [CmdW-1:0]     cmd_i             = '0;
  logic [MeasW-1:0]    measured_tenths_i = '0;
  logic [SpW-1:0]      setpoint_tenths_i = '0;
  logic                out_valid_o;
  logic                out_stall_i       = 1'b0;
  logic [HourW-1:0]    hours_left_o;
  logic [MinW-1:0]     minutes_left_o;
  logic [SecW-1:0]     seconds_left_o;
  logic [ModeW-1:0]    step_mode_o;
  logic                cooking_o;
  logic                heater_on_o;
  logic                buzzer_pulse_o;

  cooking_timer_thermostat_unit i_dut (.*);

  // controller state as the bench sees it, plus the two settings
  cooker_view_t     cooker;
  logic [HystW-1:0] band_cfg;
  logic [HourW-1:0] limit_cfg;

  cooker_view_t expected_views [$];
  int           mismatches    = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_req      = 1'b0;
  int           hold_left     = 0;

  directed_row_t directed_rows [DirectedRows] = '{
    // idle controller: tick, start and sample change nothing
    '{CMD_TICK,   0,     0,    1'b1, CLEARED},
    '{CMD_START,  0,     0,    1'b1, CLEARED},
    '{CMD_SAMPLE, 0,     2000, 1'b1, CLEARED},
    '{CMD_UP,     0,     0,    1'b1, '{5'd0, 6'd0, 6'd1, MODE_SEC, 1'b0, 1'b0, 1'b0}},
    '{CMD_MODE,   0,     0,    1'b0, '0},
    '{CMD_UP,     0,     0,    1'b0, '0},
    '{CMD_MODE,   0,     0,    1'b0, '0},
    '{CMD_MODE,   0,     0,    1'b0, '0},
    '{CMD_MODE,   0,     0,    1'b0, '0},
    // hour steps up to the reset limit, the one reaching it clears minutes and seconds
    '{CMD_UP,     0,     0,    1'b0, '0},
    '{CMD_UP,     0,     0,    1'b0, '0},
    '{CMD_UP,     0,     0,    1'b0, '0},
    '{CMD_UP,     0,     0,    1'b0, '0},
    '{CMD_UP,     0,     0,    1'b0, '0},
    '{CMD_UP,     0,     0,    1'b1, '{5'd5, 6'd0, 6'd0, MODE_HOUR, 1'b0, 1'b0, 1'b0}},
    // mode wraps to seconds, down borrows through the hours
    '{CMD_MODE,   0,     0,    1'b0, '0},
    '{CMD_DOWN,   0,     0,    1'b0, '0},
    '{CMD_START,  0,     0,    1'b0, '0},
    '{CMD_SAMPLE, 0,     2000, 1'b0, '0},
    '{CMD_SAMPLE, 2005,  2000, 1'b0, '0},
    '{CMD_SAMPLE, 10000, 0,    1'b0, '0},
    '{CMD_SAMPLE, 0,     2000, 1'b0, '0},
    '{CMD_STOP,   0,     0,    1'b1, '{5'd4, 6'd59, 6'd59, MODE_SEC, 1'b0, 1'b0, 1'b0}},
    '{CMD_CLEAR,  0,     0,    1'b1, CLEARED},
    // short countdown running out with the heater on
    '{CMD_UP,     0,     0,    1'b0, '0},
    '{CMD_START,  0,     0,    1'b0, '0},
    '{CMD_SAMPLE, 0,     2000, 1'b0, '0},
    '{CMD_TICK,   0,     0,    1'b0, '0},
    '{CMD_TICK,   0,     0,    1'b1, '{5'd0, 6'd0, 6'd0, MODE_SEC, 1'b0, 1'b0, 1'b1}}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void clear_time();
    cooker.hours   = '0;
    cooker.minutes = '0;
    cooker.seconds = '0;
  endfunction

  function automatic void add_minutes(int n);
    int m;
    m = int'(cooker.minutes) + n;
    if (m <= int'(MinMax)) begin
      cooker.minutes = MinW'(m);
    end else begin
      cooker.minutes = MinW'(m - 60);
      cooker.hours   = cooker.hours + 1'b1;
    end
  endfunction

  function automatic void add_seconds(int n);
    int s;
    s = int'(cooker.seconds) + n;
    if (s <= int'(SecMax)) begin
      cooker.seconds = SecW'(s);
    end else begin
      cooker.seconds = SecW'(s - 60);
      add_minutes(1);
    end
  endfunction

  function automatic void take_seconds(int n);
    int s;
    s = int'(cooker.seconds);
    if (s >= n) begin
      cooker.seconds = SecW'(s - n);
    end else if (cooker.minutes != '0) begin
      cooker.minutes = cooker.minutes - 1'b1;
      cooker.seconds = SecW'(s + 60 - n);
    end else if (cooker.hours != '0) begin
      cooker.hours   = cooker.hours - 1'b1;
      cooker.minutes = MinMax;
      cooker.seconds = SecW'(s + 60 - n);
    end else begin
      clear_time();
    end
  endfunction

  function automatic void take_minutes(int n);
    int m;
    m = int'(cooker.minutes);
    if (m >= n) begin
      cooker.minutes = MinW'(m - n);
    end else if (cooker.hours != '0) begin
      cooker.hours   = cooker.hours - 1'b1;
      cooker.minutes = MinW'(m + 60 - n);
    end else begin
      clear_time();
    end
  endfunction

  function automatic cooker_view_t apply_event(cmd_e c, int meas, int sp);
    logic time_left;
    int   band;
    time_left = (cooker.hours != '0) || (cooker.minutes != '0) || (cooker.seconds != '0);
    band = int'(band_cfg);
    cooker.buzzer = 1'b0;
    case (c)
      CMD_TICK: begin
        if (cooker.cooking) begin
          if (time_left) begin
            take_seconds(1);
          end else begin
            cooker.cooking = 1'b0;
            cooker.heater  = 1'b0;
            cooker.buzzer  = 1'b1;
          end
        end
      end
      CMD_MODE: cooker.mode = (cooker.mode >= MODE_HOUR) ? MODE_SEC : cooker.mode + 1'b1;
      CMD_START: begin
        if (time_left) cooker.cooking = 1'b1;
      end
      CMD_STOP: begin
        cooker.cooking = 1'b0;
        cooker.heater  = 1'b0;
      end
      CMD_UP: begin
        if (cooker.hours < limit_cfg) begin
          case (cooker.mode)
            MODE_SEC:     add_seconds(1);
            MODE_TEN_SEC: add_seconds(10);
            MODE_MIN:     add_minutes(1);
            MODE_TEN_MIN: add_minutes(10);
            MODE_HOUR:    cooker.hours = cooker.hours + 1'b1;
            default: ;
          endcase
          // reaching the limit drops minutes and seconds whatever the mode
          if (cooker.hours == limit_cfg) begin
            cooker.minutes = '0;
            cooker.seconds = '0;
          end
        end
      end
      CMD_DOWN: begin
        case (cooker.mode)
          MODE_SEC:     take_seconds(1);
          MODE_TEN_SEC: take_seconds(10);
          MODE_MIN:     take_minutes(1);
          MODE_TEN_MIN: take_minutes(10);
          MODE_HOUR: begin
            if (cooker.hours != '0) cooker.hours = cooker.hours - 1'b1;
            else clear_time();
          end
          default: ;
        endcase
      end
      CMD_CLEAR: begin
        clear_time();
        cooker.cooking = 1'b0;
        cooker.heater  = 1'b0;
      end
      default: begin
        if (cooker.cooking) begin
          if (meas < sp - band) cooker.heater = 1'b1;
          else if (meas > sp + band) cooker.heater = 1'b0;
        end
      end
    endcase
    return cooker;
  endfunction

  task automatic offer_event(input cmd_e c, input int meas, input int sp,
                             input bit typed, input cooker_view_t typed_view);
    cooker_view_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    cmd_i             <= c;
    measured_tenths_i <= MeasW'(meas);
    setpoint_tenths_i <= SpW'(sp);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_event(c, meas, sp);
    expected_views.push_back(typed ? typed_view : predicted);
  endtask

  task automatic random_events(input int count);
    int   pick;
    int   meas;
    int   sp;
    int   band;
    cmd_e c;
    band = int'(band_cfg);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      // mostly ticks and edits, few stops and clears so the countdown gets going
      if (pick < 24)      c = CMD_TICK;
      else if (pick < 32) c = CMD_MODE;
      else if (pick < 42) c = CMD_START;
      else if (pick < 46) c = CMD_STOP;
      else if (pick < 62) c = CMD_UP;
      else if (pick < 77) c = CMD_DOWN;
      else if (pick < 80) c = CMD_CLEAR;
      else                c = CMD_SAMPLE;
      sp = $urandom_range(2000);
      if ($urandom_range(1) == 0) begin
        meas = $urandom_range(10000);
      end else begin
        // around the band edges
        meas = sp + int'($urandom_range(2 * band + 4)) - (band + 2);
        if (meas < 0) meas = 0;
        else if (meas > 10000) meas = 10000;
      end
      offer_event(c, meas, sp, 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_settings(input int band, input int limit);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_HYST;
    cfg_wdata_i <= CfgDataW'(band);
    @(posedge clk_i);
    cfg_index_i <= REG_HOUR_LIMIT;
    cfg_wdata_i <= CfgDataW'(limit);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    band_cfg  = HystW'(band);
    limit_cfg = HourW'(limit);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      if (mismatches < 10) $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // receiver side: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    cooker_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_views.size() == 0) begin
        if (mismatches < 10) $display("result transfer with nothing expected at %0t", $time);
        mismatches++;
      end else begin
        want = expected_views.pop_front();
        compare_field("hours_left", hours_left_o, want.hours);
        compare_field("minutes_left", minutes_left_o, want.minutes);
        compare_field("seconds_left", seconds_left_o, want.seconds);
        compare_field("step_mode", step_mode_o, want.mode);
        compare_field("cooking", cooking_o, want.cooking);
        compare_field("heater_on", heater_on_o, want.heater);
        compare_field("buzzer_pulse", buzzer_pulse_o, want.buzzer);
      end
    end
  end

  initial begin
    cooker    = '0;
    band_cfg  = HystReset;
    limit_cfg = LimitReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 7;
    recv_idle_pct = 78;
    foreach (directed_rows[r]) begin
      offer_event(directed_rows[r].cmd, directed_rows[r].meas, directed_rows[r].sp,
                  directed_rows[r].typed, directed_rows[r].view);
    end
    drain_results();
    write_settings(0, 23);
    random_events(240);

    drain_results();
    send_idle_pct = 78;
    recv_idle_pct = 7;
    write_settings(1000, 1);
    random_events(240);

    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings($urandom_range(1000), $urandom_range(23, 1));
    // receiver holds off while transfers keep coming, so the input backs up
    hold_req = 1'b1;
    random_events(40);
    random_events(200);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ctt_pkg.sv
rtl/core/cooking_timer_thermostat_unit.sv
rtl/core/ctt_checker.sv
bench/tb.sv
